/* rtl/core/abde_pkg.sv */
// ----------------------------------------------------------------------------
// Ansari-Bradley distribution package
// Shared constants, control types and bound helpers for the distribution block.
// ----------------------------------------------------------------------------
package abde_pkg;

    localparam int MAX_M      = 16;
    localparam int MAX_N      = 16;
    localparam int STAT_W     = 8;
    localparam int STAT_SPAN  = 256;
    localparam int SIZE_W     = 5;
    localparam int CNT_W      = 32;
    localparam int PROB_W     = 33;
    localparam int ROW_DEPTH  = (MAX_N + 1) * STAT_SPAN;
    localparam int ROW_ADDR_W = 13;
    localparam int DIV_CNT_W  = 5;

    localparam logic [PROB_W-1:0] ONE_PROB = 33'h1_0000_0000;

    // Configuration register indexes.
    localparam logic REG_M_SIZE = 1'b0;
    localparam logic REG_N_SIZE = 1'b1;

    // Query kinds.
    localparam logic KIND_DIST  = 1'b0;
    localparam logic KIND_QUANT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RB_RD,
        ST_RB_WR,
        ST_CUM_RD,
        ST_CUM_WR,
        ST_ROUTE,
        ST_MEM_RD,
        ST_DIV_LD,
        ST_DIV_RUN,
        ST_Q_MUL,
        ST_Q_RD,
        ST_Q_CHK,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic rb_init;
        logic rb_step;
        logic sweep;
        logic cum_init;
        logic cum_step;
        logic div_load;
        logic div_step;
        logic q_init;
        logic q_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rb_last;
        logic cum_last;
        logic fast;
        logic kind;
        logic div_last;
        logic q_more;
        logic out_free;
    } t_stat;

    // Lowest statistic for a first sample of size i: (i+1)^2/4.
    function automatic logic [8:0] low_bound(input logic [SIZE_W-1:0] i);
        logic [9:0] sq;
        sq = 10'({5'd0, i} + 10'd1) * 10'({5'd0, i} + 10'd1);
        return {1'b0, sq[9:2]};
    endfunction

    // Highest statistic: low bound plus i*j/2.
    function automatic logic [8:0] high_bound(input logic [SIZE_W-1:0] i,
                                               input logic [SIZE_W-1:0] j);
        logic [9:0] pr;
        pr = 10'({5'd0, i} * {5'd0, j});
        return low_bound(i) + {1'b0, pr[8:1]};
    endfunction

endpackage

/* rtl/core/abde_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/abde_ctrl.sv */
// ----------------------------------------------------------------------------
// Ansari-Bradley controller
// Sequences table rebuild, cumulative sweep and the two query kinds.
// ----------------------------------------------------------------------------
module abde_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cfg_we,
    input  abde_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output abde_pkg::t_cmd  o_cmd
);
    import abde_pkg::*;

    t_state r_state, n_state;
    logic   r_table_ready, n_table_ready;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    // State and table-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_table_ready <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
        end
    end

    // Table is stale after any register write, valid after the sweep.
    always_comb begin
        n_table_ready = r_table_ready;
        if (i_cfg_we) begin
            n_table_ready = 1'b0;
        end else if (r_state == ST_CUM_WR && i_stat.cum_last) begin
            n_table_ready = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = r_table_ready ? ST_ROUTE : ST_RB_RD;
                end
            end
            ST_RB_RD:  n_state = ST_RB_WR;
            ST_RB_WR:  n_state = i_stat.rb_last ? ST_CUM_RD : ST_RB_RD;
            ST_CUM_RD: n_state = ST_CUM_WR;
            ST_CUM_WR: n_state = i_stat.cum_last ? ST_ROUTE : ST_CUM_RD;
            ST_ROUTE: begin
                if (i_stat.fast) begin
                    n_state = ST_DONE;
                end else if (i_stat.kind == KIND_DIST) begin
                    n_state = ST_MEM_RD;
                end else begin
                    n_state = ST_Q_MUL;
                end
            end
            ST_MEM_RD:  n_state = ST_DIV_LD;
            ST_DIV_LD:  n_state = ST_DIV_RUN;
            ST_DIV_RUN: n_state = i_stat.div_last ? ST_DONE : ST_DIV_RUN;
            ST_Q_MUL:   n_state = ST_Q_RD;
            ST_Q_RD:    n_state = ST_Q_CHK;
            ST_Q_CHK:   n_state = i_stat.q_more ? ST_Q_RD : ST_DONE;
            ST_DONE:    n_state = i_stat.out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.load_in  = w_accept;
        o_cmd.rb_init  = w_accept && !r_table_ready;
        o_cmd.rb_step  = (r_state == ST_RB_WR);
        o_cmd.cum_init = (r_state == ST_RB_WR) && i_stat.rb_last;
        o_cmd.sweep    = (r_state == ST_CUM_RD) || (r_state == ST_CUM_WR);
        o_cmd.cum_step = (r_state == ST_CUM_WR);
        o_cmd.div_load = (r_state == ST_DIV_LD);
        o_cmd.div_step = (r_state == ST_DIV_RUN);
        o_cmd.q_init   = (r_state == ST_Q_MUL);
        o_cmd.q_step   = (r_state == ST_Q_CHK) && i_stat.q_more;
        o_cmd.out_load = (r_state == ST_DONE) && i_stat.out_free;
    end

endmodule

/* rtl/core/abde_dpath.sv */
// ----------------------------------------------------------------------------
// Ansari-Bradley datapath
// Count table memories, cumulative sums, divider, quantile scan, result reg.
// ----------------------------------------------------------------------------
module abde_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  abde_pkg::t_cmd                   i_cmd,
    output abde_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [abde_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                            i_kind,
    input  logic [abde_pkg::STAT_W-1:0]     i_stat_value,
    input  logic [abde_pkg::PROB_W-1:0]     i_prob_in,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [abde_pkg::PROB_W-1:0]     o_prob_out,
    output logic [abde_pkg::STAT_W-1:0]     o_quantile,
    output logic                            o_bad_prob
);
    import abde_pkg::*;

    logic [SIZE_W-1:0]     r_m_size, r_n_size;
    logic [SIZE_W-1:0]     w_m, w_n;
    logic [SIZE_W-1:0]     r_i, r_j;
    logic [STAT_W-1:0]     r_k;
    logic                  r_kind;
    logic [STAT_W-1:0]     r_stat;
    logic [PROB_W-1:0]     r_prob;
    logic [CNT_W-1:0]      r_run, r_total;
    logic [CNT_W-1:0]      r_rem;
    logic [PROB_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [STAT_W-1:0]     r_q;
    logic [63:0]           r_prod;
    logic                  r_out_valid;
    logic [PROB_W-1:0]     r_prob_out;
    logic [STAT_W-1:0]     r_quant;
    logic                  r_bad;

    logic [8:0]            w_lo_i, w_hi_i, w_lo_m, w_hi_m, w_top;
    logic [SIZE_W-1:0]     w_shift, w_jm1;
    logic [5:0]            w_ijsum;
    logic [ROW_ADDR_W-1:0] w_addr_cur, w_addr_prev, w_a_raddr, w_b_raddr, w_waddr;
    logic [CNT_W-1:0]      w_a_rd, w_b_rd, w_cur_d, w_prev_d, w_c_rd;
    logic [CNT_W-1:0]      w_v, w_sum;
    logic                  w_in_sup;
    logic [STAT_W-1:0]     w_c_raddr, w_k_minus;
    logic [PROB_W-1:0]     w_r2, w_thresh;
    logic                  w_ge, w_round, w_out_free;
    logic [PROB_W-1:0]     w_prob_res;
    logic [STAT_W-1:0]     w_quant_res;
    logic                  w_bad_res;

    // Sample sizes above the table limits are clamped.
    assign w_m = (r_m_size > SIZE_W'(MAX_M)) ? SIZE_W'(MAX_M) : r_m_size;
    assign w_n = (r_n_size > SIZE_W'(MAX_N)) ? SIZE_W'(MAX_N) : r_n_size;

    assign w_lo_i  = low_bound(r_i);
    assign w_hi_i  = high_bound(r_i, r_j);
    assign w_lo_m  = low_bound(w_m);
    assign w_hi_m  = high_bound(w_m, w_n);
    assign w_top   = (w_hi_m > 9'(STAT_SPAN - 1)) ? 9'(STAT_SPAN - 1) : w_hi_m;
    assign w_ijsum = {1'b0, r_i} + {1'b0, r_j} + 6'd1;
    assign w_shift = w_ijsum[5:1];
    assign w_jm1   = (r_j == '0) ? '0 : r_j - 1'b1;
    assign w_k_minus = r_k - {3'd0, w_shift};

    // Ping-pong row memories: the row being built goes to A on even i, B on odd i.
    assign w_addr_cur  = i_cmd.sweep ? {w_n, r_k} : {w_jm1, r_k};
    assign w_addr_prev = {r_j, w_k_minus};
    assign w_a_raddr   = (i_cmd.sweep || !r_i[0]) ? w_addr_cur : w_addr_prev;
    assign w_b_raddr   = (i_cmd.sweep ||  r_i[0]) ? w_addr_cur : w_addr_prev;
    assign w_cur_d     = r_i[0] ? w_b_rd : w_a_rd;
    assign w_prev_d    = r_i[0] ? w_a_rd : w_b_rd;
    assign w_waddr     = {r_j, r_k};

    abde_ram #(.WIDTH(CNT_W), .DEPTH(ROW_DEPTH)) u_row_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rb_step && !r_i[0]),
        .i_waddr (w_waddr),
        .i_wdata (w_v),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rd)
    );

    abde_ram #(.WIDTH(CNT_W), .DEPTH(ROW_DEPTH)) u_row_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rb_step && r_i[0]),
        .i_waddr (w_waddr),
        .i_wdata (w_v),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rd)
    );

    // Recurrence for one table entry.
    always_comb begin
        w_in_sup = ({1'b0, r_k} >= w_lo_i) && ({1'b0, r_k} <= w_hi_i);
        w_v      = '0;
        if (w_in_sup) begin
            if (r_i == '0) begin
                w_v = CNT_W'(r_k == '0);
            end else if (r_j == '0) begin
                w_v = CNT_W'({1'b0, r_k} == w_lo_i);
            end else begin
                w_v = w_cur_d + ((r_k >= {3'd0, w_shift}) ? w_prev_d : '0);
            end
        end
    end

    // Cumulative counts of the final row.
    assign w_sum     = r_run + w_cur_d;
    assign w_c_raddr = (r_kind == KIND_QUANT) ? r_q : r_stat;

    abde_ram #(.WIDTH(CNT_W), .DEPTH(STAT_SPAN)) u_cum (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cum_step),
        .i_waddr (r_k),
        .i_wdata (w_sum),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rd)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_size <= SIZE_W'(1);
            r_n_size <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_M_SIZE) begin
                r_m_size <= i_cfg_data;
            end
            if (i_cfg_addr == REG_N_SIZE) begin
                r_n_size <= i_cfg_data;
            end
        end
    end

    // Table counters and running sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rb_init) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (i_cmd.rb_step) begin
            r_k <= r_k + 1'b1;
            if (r_k == STAT_W'(STAT_SPAN - 1)) begin
                if (r_j == w_n) begin
                    r_j <= '0;
                    if (r_i != w_m) begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end else if (i_cmd.cum_step) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.cum_init) begin
            r_run <= '0;
        end else if (i_cmd.cum_step) begin
            r_run <= w_sum;
            if (r_k == STAT_W'(STAT_SPAN - 1)) begin
                r_total <= w_sum;
            end
        end
    end

    // Query latch, divider and quantile scan.
    assign w_r2 = {r_rem, 1'b0};
    assign w_ge = w_r2 >= {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_stat <= i_stat_value;
            r_prob <= i_prob_in;
        end
        if (i_cmd.div_load) begin
            r_cnt <= '0;
            if (w_c_rd >= r_total) begin
                r_rem <= w_c_rd - r_total;
                r_quo <= PROB_W'(1);
            end else begin
                r_rem <= w_c_rd;
                r_quo <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? CNT_W'(w_r2 - {1'b0, r_total}) : w_r2[CNT_W-1:0];
            r_quo <= {r_quo[PROB_W-2:0], w_ge};
        end
        if (i_cmd.q_init) begin
            r_q    <= w_lo_m[STAT_W-1:0];
            r_prod <= r_prob[CNT_W-1:0] * r_total;
        end else if (i_cmd.q_step) begin
            r_q <= r_q + 1'b1;
        end
    end

    // Scan stops at the first entry whose count times 2^32 reaches p times total.
    assign w_thresh = {1'b0, r_prod[63:32]} + PROB_W'(|r_prod[31:0]);
    assign w_round  = w_r2 >= {1'b0, r_total};

    // Result selection.
    always_comb begin
        w_prob_res  = '0;
        w_quant_res = '0;
        w_bad_res   = 1'b0;
        if (r_kind == KIND_DIST) begin
            if ({1'b0, r_stat} < w_lo_m) begin
                w_prob_res = '0;
            end else if ({1'b0, r_stat} > w_hi_m) begin
                w_prob_res = ONE_PROB;
            end else begin
                w_prob_res = r_quo + PROB_W'(w_round);
            end
        end else begin
            if (r_prob > ONE_PROB) begin
                w_bad_res = 1'b1;
            end else if (r_prob == '0) begin
                w_quant_res = w_lo_m[STAT_W-1:0];
            end else if (r_prob == ONE_PROB) begin
                w_quant_res = w_hi_m[STAT_W-1:0];
            end else begin
                w_quant_res = r_q;
            end
        end
    end

    // Output register; a new result may load as the old one leaves.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_prob_out <= w_prob_res;
            r_quant    <= w_quant_res;
            r_bad      <= w_bad_res;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.rb_last  = (r_k == STAT_W'(STAT_SPAN - 1)) && (r_j == w_n) && (r_i == w_m);
        o_stat.cum_last = (r_k == STAT_W'(STAT_SPAN - 1));
        o_stat.kind     = r_kind;
        o_stat.fast     = (r_kind == KIND_DIST)
                        ? (({1'b0, r_stat} < w_lo_m) || ({1'b0, r_stat} > w_hi_m))
                        : ((r_prob == '0) || (r_prob >= ONE_PROB));
        o_stat.div_last = (r_cnt == {DIV_CNT_W{1'b1}});
        o_stat.q_more   = ({1'b0, r_q} < w_top) && ({1'b0, w_c_rd} < w_thresh);
        o_stat.out_free = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_prob_out  = r_prob_out;
    assign o_quantile  = r_quant;
    assign o_bad_prob  = r_bad;

endmodule

/* rtl/core/ansari_bradley_exact_distribution.sv */
// ----------------------------------------------------------------------------
// Ansari-Bradley exact null distribution
// Builds the count table for sample sizes m, n and answers tail/quantile queries.
// ----------------------------------------------------------------------------
// Usage: write m_size (index 0) and n_size (index 1) through the config port
// while the block is idle. Each query arrives on the s_axis channel; tuser is
// the query kind (0 = lower-tail probability, 1 = quantile). One result per
// query leaves on m_axis.
// The first query after reset or after a register write rebuilds the table:
// each of the (m+1)*(n+1)*256 entries is read and then written, and then each
// of the 256 cumulative sums is read and written. A probability query in
// range is worked by the 32-step restoring divider. A quantile query scans
// the statistics one at a time, with one cumulative memory read and compare
// per step. Out-of-range queries go straight from the route state to the
// result register.
// One query is worked on at a time; s_axis_tready is high only when idle.
// A finished result sits in the output register while the receiver stalls;
// the next query may already be taken, and its result waits until that slot
// frees. Reset clears the handshake state and marks the table as stale.
// ----------------------------------------------------------------------------
module ansari_bradley_exact_distribution (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [7:0] stat_value, [40:8] prob_in, rest zero
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [32:0] prob_out, [40:33] quantile, rest zero
    output logic        m_axis_tuser,   // [0] bad_prob
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [4:0]  i_cfg_data
);
    import abde_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [PROB_W-1:0] w_prob_out;
    logic [STAT_W-1:0] w_quantile;

    // Sequencer.
    abde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cfg_we   (i_cfg_we),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Table, arithmetic and result register.
    abde_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (s_axis_tuser),
        .i_stat_value (s_axis_tdata[7:0]),
        .i_prob_in    (s_axis_tdata[40:8]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_prob_out   (w_prob_out),
        .o_quantile   (w_quantile),
        .o_bad_prob   (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, w_quantile, w_prob_out};

endmodule

/* rtl/core/abde_checker.sv */
// ----------------------------------------------------------------------------
// Ansari-Bradley port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module abde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One query at a time: ready falls after each input transaction.
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a query is in progress");

    // A bad probability carries no quantile and no probability.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[40:0] == 41'd0)
        else $error("bad probability with nonzero payload");

    // Probability never exceeds one.
    a_prob_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && (m_axis_tdata[31:0] != 32'd0)))
        else $error("probability above one");

    // At most one of probability and quantile is nonzero.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:0] == 33'd0) || (m_axis_tdata[40:33] == 8'd0))
        else $error("both probability and quantile set");

endmodule

bind ansari_bradley_exact_distribution abde_checker u_abde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
